// ===== design/ptc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the pressure/temperature
// compensation core. No dependencies.
package ptc_pkg;

  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 64;
  localparam int FRONT_STAGES  = 12;
  localparam int DIV_BITS      = 64;
  localparam int BACK_STAGES   = DIV_BITS + 8;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [63:0] TF_OFFSET       = 64'd128000;
  localparam logic [63:0] PRESS_FULLSCALE = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE     = 64'd3125;
  localparam logic [63:0] V1_BIAS         = 64'h0000_8000_0000_0000;  // 2^47

  typedef enum logic [1:0] {
    REG_TEMP_CALIB  = 2'd0,
    REG_PRESS_LOW   = 2'd1,
    REG_PRESS_HIGH  = 2'd2,
    REG_PRESS_LAST  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } calib_t;

  // one item handed from front to back
  typedef struct packed {
    logic [31:0] temp;
    logic [63:0] num;
    logic [31:0] den;
    logic        inv;
  } qitem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // partial products of a 64x64 multiply, low 64 bits kept
  typedef struct packed {
    logic [63:0] lo;
    logic [31:0] cr;
  } pp_t;

  function automatic pp_t pp_mul(input logic [63:0] a, input logic [63:0] b);
    pp_t r;
    r.lo = 64'(a[31:0]) * 64'(b[31:0]);
    r.cr = 32'(a[31:0] * b[63:32]) + 32'(a[63:32] * b[31:0]);
    return r;
  endfunction

  function automatic logic [63:0] pp_sum(input pp_t p);
    return p.lo + {p.cr, 32'b0};
  endfunction

  function automatic logic [63:0] sx64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx32(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// ===== design/ptc_front.sv =====
// Front pipeline: accepts raw readings, computes temperature and the pressure
// dividend/divisor. Depends on ptc_pkg.
module ptc_front (
  input  logic            clk,
  input  logic            rst,
  input  ptc_pkg::calib_t calib,
  input  logic            item_valid,
  output logic            item_stall,
  input  logic [19:0]     raw_temperature,
  input  logic [19:0]     raw_pressure,
  input  ptc_pkg::qstat_t qstat,
  output logic            push,
  output ptc_pkg::qitem_t push_item
);
  import ptc_pkg::*;

  logic [FRONT_STAGES-1:0] vld;
  logic en;

  logic [31:0] t1e, t2e, t3e;
  logic [63:0] p1e, p2e, p3e, p4e, p5e, p6e;
  logic [31:0] at, sq_sh, m3_sh, tm;
  logic [63:0] e_sum, e_shr, f_sum, f_shr;

  logic [31:0] d1_1, d2_1, m1_2, sq_2, tv1_3, m3_3, tf_4;
  logic [19:0] ap_1, ap_2, ap_3, ap_4, ap_5, ap_6, ap_7, ap_8, ap_9;
  logic [31:0] temp_5, temp_6, temp_7, temp_8, temp_9, temp_10, temp_11, temp_12;
  logic [63:0] v1_5, vv_7, v1p5_7, v1p2_7, v1p5_8, v1p2_8, v2_9, v1b_9;
  logic [63:0] x_10, n_10, num_12;
  logic [31:0] den_12;
  pp_t ppa_6, ppb_6, ppc_6, ppd_8, ppe_8, ppf_11, ppg_11;

  assign t1e = {16'b0, calib.t1};
  assign t2e = sx32(calib.t2);
  assign t3e = sx32(calib.t3);
  assign p1e = {48'b0, calib.p1};
  assign p2e = sx64(calib.p2);
  assign p3e = sx64(calib.p3);
  assign p4e = sx64(calib.p4);
  assign p5e = sx64(calib.p5);
  assign p6e = sx64(calib.p6);

  assign en         = !(vld[FRONT_STAGES-1] && qstat.full);
  assign item_stall = !en;
  assign push       = vld[FRONT_STAGES-1] && en;

  assign at    = {12'b0, raw_temperature};
  assign sq_sh = $signed(sq_2) >>> 12;
  assign m3_sh = $signed(m3_3) >>> 14;
  assign tm    = (tf_4 << 2) + tf_4 + 32'd128;
  assign e_sum = pp_sum(ppe_8);
  assign e_shr = $signed(e_sum) >>> 8;
  assign f_sum = pp_sum(ppf_11);
  assign f_shr = $signed(f_sum) >>> 33;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[FRONT_STAGES-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // temperature, 32-bit wrap
      d1_1    <= (at >> 3) - (t1e << 1);
      d2_1    <= (at >> 4) - t1e;
      ap_1    <= raw_pressure;
      m1_2    <= d1_1 * t2e;
      sq_2    <= d2_1 * d2_1;
      ap_2    <= ap_1;
      tv1_3   <= $signed(m1_2) >>> 11;
      m3_3    <= sq_sh * t3e;
      ap_3    <= ap_2;
      tf_4    <= tv1_3 + m3_sh;
      ap_4    <= ap_3;
      temp_5  <= $signed(tm) >>> 8;
      v1_5    <= {{32{tf_4[31]}}, tf_4} - TF_OFFSET;
      ap_5    <= ap_4;
      // pressure polynomial, 64-bit wrap
      ppa_6   <= pp_mul(v1_5, v1_5);
      ppb_6   <= pp_mul(v1_5, p5e);
      ppc_6   <= pp_mul(v1_5, p2e);
      temp_6  <= temp_5;
      ap_6    <= ap_5;
      vv_7    <= pp_sum(ppa_6);
      v1p5_7  <= pp_sum(ppb_6);
      v1p2_7  <= pp_sum(ppc_6);
      temp_7  <= temp_6;
      ap_7    <= ap_6;
      ppd_8   <= pp_mul(vv_7, p6e);
      ppe_8   <= pp_mul(vv_7, p3e);
      v1p5_8  <= v1p5_7;
      v1p2_8  <= v1p2_7;
      temp_8  <= temp_7;
      ap_8    <= ap_7;
      v2_9    <= pp_sum(ppd_8) + (v1p5_8 << 17) + (p4e << 35);
      v1b_9   <= e_shr + (v1p2_8 << 12);
      temp_9  <= temp_8;
      ap_9    <= ap_8;
      x_10    <= V1_BIAS + v1b_9;
      n_10    <= ((PRESS_FULLSCALE - {44'b0, ap_9}) << 31) - v2_9;
      temp_10 <= temp_9;
      ppf_11  <= pp_mul(x_10, p1e);
      ppg_11  <= pp_mul(n_10, PRESS_SCALE);
      temp_11 <= temp_10;
      den_12  <= f_shr[31:0];   // fits 32 bits signed after the shift
      num_12  <= pp_sum(ppg_11);
      temp_12 <= temp_11;
    end
  end

  assign push_item.temp = temp_12;
  assign push_item.num  = num_12;
  assign push_item.den  = den_12;
  assign push_item.inv  = (den_12 == 32'd0);

endmodule

// ===== design/ptc_queue.sv =====
// Small register FIFO between the front and back pipelines.
// Depends on ptc_pkg.
module ptc_queue #(
  parameter int DEPTH = ptc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ptc_pkg::qitem_t push_item,
  input  logic            pop,
  output ptc_pkg::qitem_t head,
  output ptc_pkg::qstat_t stat
);
  import ptc_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  qitem_t        mem [0:DEPTH-1];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign head       = mem[rptr];
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/ptc_back.sv =====
// Back pipeline: radix-2 signed divide, then the pressure correction terms.
// Depends on ptc_pkg.
module ptc_back (
  input  logic               clk,
  input  logic               rst,
  input  ptc_pkg::calib_t    calib,
  input  ptc_pkg::qstat_t    qstat,
  input  ptc_pkg::qitem_t    head,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] temperature_centi,
  output logic [31:0]        pressure_q24_8,
  output logic               pressure_invalid
);
  import ptc_pkg::*;

  logic [BACK_STAGES-1:0] vb;
  logic en;

  logic [31:0] rem  [0:DIV_BITS];
  logic [63:0] nq   [0:DIV_BITS];
  logic [31:0] ud   [0:DIV_BITS];
  logic        sgn  [0:DIV_BITS];
  logic [31:0] temp [0:DIV_BITS];
  logic        inv  [0:DIV_BITS];

  logic [31:0] tc [1:6];
  logic        ic [1:6];

  logic [63:0] p7e, p8e, p9e;
  logic [63:0] q13, w_shr, p8p_shr, s_shr, res;
  logic [63:0] p_1, p_2, p_3, p_4, p_5, q13_2, q13_3, p9q_3, p8p_3, p8p_4, p8p_5;
  logic [63:0] w_5, s_6;
  pp_t pph_2, ppi_2, ppj_4;

  assign p7e = sx64(calib.p7);
  assign p8e = sx64(calib.p8);
  assign p9e = sx64(calib.p9);

  assign en           = !(vb[BACK_STAGES-1] && result_stall);
  assign pop          = en && !qstat.empty;
  assign result_valid = vb[BACK_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else if (en) begin
      vb <= {vb[BACK_STAGES-2:0], !qstat.empty};
    end
  end

  // operand magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= '0;
      nq[0]   <= head.num[63] ? (64'd0 - head.num) : head.num;
      ud[0]   <= head.den[31] ? (32'd0 - head.den) : head.den;
      sgn[0]  <= head.num[63] ^ head.den[31];
      temp[0] <= head.temp;
      inv[0]  <= head.inv;
    end
  end

  // one quotient bit per stage; remainder stays below the divisor (<= 2^31)
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem[k], nq[k][63]};
    assign ge    = (trial >= {1'b0, ud[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? 32'(trial - {1'b0, ud[k]}) : trial[31:0];
        nq[k+1]   <= {nq[k][62:0], ge};
        ud[k+1]   <= ud[k];
        sgn[k+1]  <= sgn[k];
        temp[k+1] <= temp[k];
        inv[k+1]  <= inv[k];
      end
    end
  end

  assign q13     = $signed(p_1) >>> 13;
  assign w_shr   = $signed(w_5) >>> 25;
  assign p8p_shr = $signed(p8p_5) >>> 19;
  assign s_shr   = $signed(s_6) >>> 8;
  assign res     = s_shr + (p7e << 4);

  always_ff @(posedge clk) begin
    if (en) begin
      p_1   <= sgn[DIV_BITS] ? (64'd0 - nq[DIV_BITS]) : nq[DIV_BITS];
      tc[1] <= temp[DIV_BITS];
      ic[1] <= inv[DIV_BITS];
      for (int k = 2; k <= 6; k++) begin
        tc[k] <= tc[k-1];
        ic[k] <= ic[k-1];
      end
      pph_2 <= pp_mul(p9e, q13);
      ppi_2 <= pp_mul(p8e, p_1);
      q13_2 <= q13;
      p_2   <= p_1;
      p9q_3 <= pp_sum(pph_2);
      p8p_3 <= pp_sum(ppi_2);
      q13_3 <= q13_2;
      p_3   <= p_2;
      ppj_4 <= pp_mul(p9q_3, q13_3);
      p8p_4 <= p8p_3;
      p_4   <= p_3;
      w_5   <= pp_sum(ppj_4);
      p8p_5 <= p8p_4;
      p_5   <= p_4;
      s_6   <= p_5 + w_shr + p8p_shr;
      temperature_centi <= tc[6];
      pressure_invalid  <= ic[6];
      pressure_q24_8    <= ic[6] ? 32'd0 : res[31:0];
    end
  end

endmodule

// ===== design/pressure_temperature_compensation_core.sv =====
// Pipeline: 12 front stages, one queue slot and 72 back stages, of which 64 are
// divide bits; the accepting edge itself loads the first front stage.
// Throughput: one beat per cycle unless result_stall holds the pipeline, set by
// the fully pipelined radix-2 divider.
// Reset: synchronous, active high; clears calibration registers, pipeline valids
// and queue pointers. No clearing pass; the block is ready the cycle after reset.
module pressure_temperature_compensation_core #(
  parameter int QUEUE_DEPTH = ptc_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  // APB-style configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ptc_pkg::ADDR_W-1:0] paddr,
  input  logic [ptc_pkg::DATA_W-1:0] pwdata,
  output logic [ptc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  // input channel
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [19:0]                raw_temperature,
  input  logic [19:0]                raw_pressure,
  // result channel
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [31:0]         temperature_centi,
  output logic [31:0]                pressure_q24_8,
  output logic                       pressure_invalid
);
  import ptc_pkg::*;

  // calibration registers, 8-byte stride
  logic [47:0] temp_calib;
  logic [63:0] press_calib_low;
  logic [63:0] press_calib_high;
  logic [15:0] press_calib_last;

  reg_idx_t reg_idx;
  logic     wr_en;
  calib_t   calib;

  logic   push, pop;
  qitem_t push_item, head;
  qstat_t qstat;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib       <= '0;
      press_calib_low  <= '0;
      press_calib_high <= '0;
      press_calib_last <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TEMP_CALIB: temp_calib       <= pwdata[47:0];
        REG_PRESS_LOW:  press_calib_low  <= pwdata;
        REG_PRESS_HIGH: press_calib_high <= pwdata;
        REG_PRESS_LAST: press_calib_last <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TEMP_CALIB: prdata = {16'b0, temp_calib};
      REG_PRESS_LOW:  prdata = press_calib_low;
      REG_PRESS_HIGH: prdata = press_calib_high;
      REG_PRESS_LAST: prdata = {48'b0, press_calib_last};
      default:        prdata = '0;
    endcase
  end

  // coefficient slices
  assign calib.t1 = temp_calib[15:0];
  assign calib.t2 = temp_calib[31:16];
  assign calib.t3 = temp_calib[47:32];
  assign calib.p1 = press_calib_low[15:0];
  assign calib.p2 = press_calib_low[31:16];
  assign calib.p3 = press_calib_low[47:32];
  assign calib.p4 = press_calib_low[63:48];
  assign calib.p5 = press_calib_high[15:0];
  assign calib.p6 = press_calib_high[31:16];
  assign calib.p7 = press_calib_high[47:32];
  assign calib.p8 = press_calib_high[63:48];
  assign calib.p9 = press_calib_last;

  // front: temperature and the divide operands
  ptc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .calib           (calib),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .raw_temperature (raw_temperature),
    .raw_pressure    (raw_pressure),
    .qstat           (qstat),
    .push            (push),
    .push_item       (push_item)
  );

  // decouples front stalls from back stalls
  ptc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  // back: divide and final pressure terms, output register is its last stage
  ptc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .calib             (calib),
    .qstat             (qstat),
    .head              (head),
    .pop               (pop),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .temperature_centi (temperature_centi),
    .pressure_q24_8    (pressure_q24_8),
    .pressure_invalid  (pressure_invalid)
  );

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("queue push while full");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("queue pop while empty");

  a_invalid_forces_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && pressure_invalid) |-> (pressure_q24_8 == 32'd0))
    else $error("invalid pressure beat carries nonzero value");

endmodule

// ===== tb/pressure_temperature_compensation_core_tb.sv =====
// Testbench for the pressure/temperature compensation core: drives reading
// pairs under random gaps and stalls, predicts each result and checks it.
// Depends on ptc_pkg and pressure_temperature_compensation_core.
module pressure_temperature_compensation_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptc_pkg::*;

  localparam int LATENCY = 85;

  typedef struct {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
  } reading_t;

  typedef struct {
    logic [31:0] temp;
    logic [31:0] press;
    logic        inv;
  } comp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [19:0] raw_temperature = '0, raw_pressure = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [31:0] temperature_centi;
  logic [31:0] pressure_q24_8;
  logic pressure_invalid;

  pressure_temperature_compensation_core dut (.*);

  always #5 clk = ~clk;

  // predictor's copy of the calibration registers
  logic [47:0] cal_temp = '0;
  logic [63:0] cal_plo = '0, cal_phi = '0;
  logic [15:0] cal_p9 = '0;

  reading_t pending_q[$];
  comp_t    expected_q[$];
  int       mismatches = 0;

  function automatic logic [63:0] asr64(logic [63:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] s16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // compensation arithmetic: 32-bit wrap for temperature, 64-bit for pressure
  function automatic comp_t compensate(reading_t r);
    comp_t c;
    logic [31:0] t1, t2, t3, d1, d2, tv1, tv2, tfine;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] v1, v2, p, q, w1, w2, num, un, ud, quo;
    t1 = {16'b0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    p1 = {48'b0, cal_plo[15:0]};
    p2 = s16(cal_plo[31:16]); p3 = s16(cal_plo[47:32]); p4 = s16(cal_plo[63:48]);
    p5 = s16(cal_phi[15:0]);  p6 = s16(cal_phi[31:16]);
    p7 = s16(cal_phi[47:32]); p8 = s16(cal_phi[63:48]); p9 = s16(cal_p9);
    d1 = {12'b0, r.raw_t} >> 3;
    d1 = d1 - (t1 << 1);
    tv1 = asr32(d1 * t2, 11);
    d2 = ({12'b0, r.raw_t} >> 4) - t1;
    tv2 = asr32(asr32(d2 * d2, 12) * t3, 14);
    tfine = tv1 + tv2;
    c.temp = asr32(tfine * 32'd5 + 32'd128, 8);
    v1 = {{32{tfine[31]}}, tfine} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
    c.press = '0;
    c.inv = 1'b0;
    if (v1 == 0) begin
      c.inv = 1'b1;
    end else begin
      p = 64'd1048576 - {44'b0, r.raw_p};
      num = ((p << 31) - v2) * 64'd3125;
      un = num[63] ? -num : num;
      ud = v1[63] ? -v1 : v1;
      quo = un / ud;
      p = (num[63] != v1[63]) ? -quo : quo;
      q = asr64(p, 13);
      w1 = asr64(p9 * q * q, 25);
      w2 = asr64(p8 * p, 19);
      p = asr64(p + w1 + w2, 8) + (p7 << 4);
      c.press = p[31:0];
    end
    return c;
  endfunction

  // accept decision latched at the rising edge
  logic item_stall_s = 1'b0;
  always @(posedge clk) item_stall_s <= item_stall;

  // driver: bursts with random gaps; payload held while stalled
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall_s) begin
        expected_q.push_back(compensate('{raw_temperature, raw_pressure}));
        void'(pending_q.pop_front());
      end
      if (item_valid && item_stall_s) begin
        // hold beat
      end else if (pending_q.size() > 0 && gap_left == 0) begin
        item_valid <= 1'b1;
        raw_temperature <= pending_q[0].raw_t;
        raw_pressure <= pending_q[0].raw_p;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        item_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // receiver stall pattern: phases of free run, random, and periodic
  int rx_cnt = 0;
  always @(negedge clk) begin
    rx_cnt++;
    case ((rx_cnt / 300) % 3)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 2) == 0);
      default: result_stall <= (rx_cnt % 5) < 2;
    endcase
  end

  // monitor
  always @(posedge clk) begin
    comp_t e;
    if (!rst && result_valid && !result_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        e = expected_q.pop_front();
        if (e.temp !== temperature_centi || e.press !== pressure_q24_8 ||
            e.inv !== pressure_invalid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp t=%0d p=%h inv=%b got t=%0d p=%h inv=%b",
                     $signed(e.temp), e.press, e.inv, temperature_centi,
                     pressure_q24_8, pressure_invalid);
        end
      end
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [63:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(8 * idx); pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_TEMP_CALIB: cal_temp = v[47:0];
      REG_PRESS_LOW:  cal_plo = v;
      REG_PRESS_HIGH: cal_phi = v;
      default:        cal_p9 = v[15:0];
    endcase
  endtask

  // sender idle and every expected result back
  task automatic wait_idle();
    while (pending_q.size() != 0 || item_valid || expected_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic drain();
    wait_idle();
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic add_item(logic [19:0] t, logic [19:0] p);
    reading_t r;
    r.raw_t = t;
    r.raw_p = p;
    pending_q.push_back(r);
  endtask

  // typical factory coefficients, so most items hit the normal path
  task automatic typical_calib();
    cfg_write(REG_TEMP_CALIB, 64'({16'hFC18 ^ 16'($urandom_range(0, 255)),
                                   16'(26000 + $urandom_range(0, 2000)),
                                   16'(27000 + $urandom_range(0, 2000))}));
    cfg_write(REG_PRESS_LOW, {16'(2800 + $urandom_range(0, 200)), 16'(4200),
                               16'hD5E0 ^ 16'($urandom_range(0, 63)),
                               16'(36000 + $urandom_range(0, 2000))});
    cfg_write(REG_PRESS_HIGH, {16'(-12000), 16'(15500), 16'hFFF9, 16'(140)});
    cfg_write(REG_PRESS_LAST, 64'(16'(6000)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset calibration: zero divisor for every item
    add_item(20'h00000, 20'h00000);
    add_item(20'hFFFFF, 20'hFFFFF);
    drain();

    typical_calib();
    add_item(20'h00000, 20'h00000);
    add_item(20'hFFFFF, 20'hFFFFF);
    add_item(20'h7E000, 20'h65000);
    add_item(20'h80000, 20'h80000);
    add_item(20'h00001, 20'hFFFFE);
    drain();

    // extreme coefficients: all ones, then a mix of sign-bit-only, all-ones and maximum positive values
    cfg_write(REG_TEMP_CALIB, 64'hFFFF_FFFF_FFFF);
    cfg_write(REG_PRESS_LOW, '1);
    cfg_write(REG_PRESS_HIGH, '1);
    cfg_write(REG_PRESS_LAST, 64'hFFFF);
    add_item(20'hFFFFF, 20'h00000);
    add_item(20'h00000, 20'hFFFFF);
    drain();
    cfg_write(REG_TEMP_CALIB, 64'h8000_8000_FFFF);
    cfg_write(REG_PRESS_LOW, 64'h8000_8000_8000_FFFF);
    cfg_write(REG_PRESS_HIGH, 64'h7FFF_8000_7FFF_8000);
    cfg_write(REG_PRESS_LAST, 64'h8000);
    add_item(20'hFFFFF, 20'hFFFFF);
    add_item(20'h12345, 20'h54321);
    drain();

    // random phases, mostly realistic coefficients, some fully random
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2) begin
        cfg_write(REG_TEMP_CALIB, {$urandom, $urandom});
        cfg_write(REG_PRESS_LOW, {$urandom, $urandom});
        cfg_write(REG_PRESS_HIGH, {$urandom, $urandom});
        cfg_write(REG_PRESS_LAST, 64'($urandom));
      end else begin
        typical_calib();
      end
      for (int i = 0; i < 100; i++) begin
        if (i == 50) begin
          // sender waits until every result is back
          wait_idle();
        end
        if ($urandom_range(0, 3) == 0) add_item(20'($urandom), 20'($urandom));
        else add_item(20'h60000 + 20'($urandom_range(0, 20'h3FFFF)),
                      20'h40000 + 20'($urandom_range(0, 20'h5FFFF)));
      end
      drain();
    end

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
